// File: design/tzba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzba_pkg
// Shared types and constants for the trace zone bump allocator.
// ----------------------------------------------------------------------------
package tzba_pkg;

   localparam int ZONE_HEADER_BYTES_DEF  = 32;
   localparam int ENTRY_HEADER_BYTES_DEF = 24;
   localparam int ALIGN_BYTES_DEF        = 8;
   localparam logic [15:0] ZONE_SIZE_RESET = 16'd4096;

   // request plus header plus alignment slack never exceeds 17 bits
   localparam int QUOT_WIDTH = 17;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_ALLOC   = 3'd0,
      CMD_COMMIT  = 3'd1,
      CMD_MARK    = 3'd2,
      CMD_RECYCLE = 3'd3,
      CMD_QUERY   = 3'd4
   } command_type;

   typedef enum logic [2:0] {
      OP_ALLOC,
      OP_COMMIT,
      OP_MARK,
      OP_RECYCLE,
      OP_QUERY,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_REFUSED = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_REJECT  = 2'd3
   } status_type;

   typedef struct packed {
      op_type                  op;
      logic [QUOT_WIDTH-1:0]   quotient;     // rounded size divided by alignment
      logic [15:0]             entry_offset;
   } queue_entry_type;

   typedef struct packed {
      logic        granted;
      logic [15:0] granted_offset;
      logic [15:0] entry_bytes;
      logic [15:0] prior_head;
      logic [1:0]  status;
      logic        zone_filled;
      logic        zone_committed;
      logic [15:0] entries_allocated;
      logic [15:0] entries_ready;
      logic [15:0] sync_offset;
      logic [31:0] zone_generation;
   } response_type;

endpackage

// File: design/tzba_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzba_front
// Decodes a command beat and works out the aligned entry size as a quotient.
// ----------------------------------------------------------------------------
module tzba_front import tzba_pkg::*; #(
   parameter int ENTRY_HEADER_BYTES = ENTRY_HEADER_BYTES_DEF,
   parameter int ALIGN_BYTES        = ALIGN_BYTES_DEF
) (
   input  logic [2:0]      command,
   input  logic [15:0]     request_size,
   input  logic [15:0]     entry_offset,
   output queue_entry_type entry
);

   // reciprocal with 30 fraction bits is exact for 17-bit dividends
   localparam int          RecipShift = 30;
   localparam logic [30:0] Recip = 31'((2**RecipShift + ALIGN_BYTES - 1) / ALIGN_BYTES);

   logic [15:0] sum16;
   logic [16:0] biased;
   logic [47:0] product;

   assign sum16   = request_size + 16'(ENTRY_HEADER_BYTES);
   assign biased  = {1'b0, sum16} + 17'(ALIGN_BYTES - 1);
   assign product = 48'(biased) * 48'(Recip);

   always_comb begin
      entry.quotient     = product[RecipShift +: QUOT_WIDTH];
      entry.entry_offset = entry_offset;
      unique case (command)
         CMD_ALLOC:   entry.op = OP_ALLOC;
         CMD_COMMIT:  entry.op = OP_COMMIT;
         CMD_MARK:    entry.op = OP_MARK;
         CMD_RECYCLE: entry.op = OP_RECYCLE;
         CMD_QUERY:   entry.op = OP_QUERY;
         default:     entry.op = OP_NONE;
      endcase
   end

endmodule

// File: design/tzba_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzba_queue
// Short flop queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
module tzba_queue import tzba_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output queue_entry_type head_entry
);

   queue_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   function automatic logic [QPTR_WIDTH-1:0] bump(input logic [QPTR_WIDTH-1:0] ptr);
      if (ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCNT_WIDTH'(push) - QCNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/tzba_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzba_back
// Executes queued commands against the zone state and holds the response.
// ----------------------------------------------------------------------------
module tzba_back import tzba_pkg::*; #(
   parameter int ZONE_HEADER_BYTES = ZONE_HEADER_BYTES_DEF,
   parameter int ALIGN_BYTES       = ALIGN_BYTES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            entry_valid,
   input  queue_entry_type entry,
   output logic            pop,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [15:0]     csr_zone_size,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output response_type    rsp
);

   localparam logic [15:0] ZoneHeader = 16'(ZONE_HEADER_BYTES);

   logic [15:0]  zone_size_ff;
   logic [15:0]  free_ptr_ff, free_ptr_in;
   logic [15:0]  alloc_cnt_ff, alloc_cnt_in;
   logic [15:0]  ready_cnt_ff, ready_cnt_in;
   logic         filled_ff, filled_in;
   logic         committed_ff, committed_in;
   logic [15:0]  ready_head_ff, ready_head_in;
   logic [15:0]  sync_point_ff, sync_point_in;
   logic [31:0]  generation_ff, generation_in;
   logic         rsp_valid_ff, rsp_valid_in;
   response_type rsp_ff, rsp_in;

   logic [QUOT_WIDTH+6:0] scaled;
   logic [15:0]           entry_bytes;
   logic [15:0]           next_ptr;
   logic [15:0]           ready_plus;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign pop       = entry_valid && (!rsp_valid_ff || rsp_ready);

   assign scaled      = (QUOT_WIDTH+7)'(entry.quotient) * (QUOT_WIDTH+7)'(ALIGN_BYTES);
   assign entry_bytes = scaled[15:0];
   assign next_ptr    = free_ptr_ff + entry_bytes;
   assign ready_plus  = ready_cnt_ff + 16'd1;

   always_comb begin
      logic       grant;
      logic [15:0] goff;
      logic [15:0] ebytes;
      logic [15:0] prior;
      status_type  stat;

      free_ptr_in   = free_ptr_ff;
      alloc_cnt_in  = alloc_cnt_ff;
      ready_cnt_in  = ready_cnt_ff;
      filled_in     = filled_ff;
      committed_in  = committed_ff;
      ready_head_in = ready_head_ff;
      sync_point_in = sync_point_ff;
      generation_in = generation_ff;
      grant         = 1'b0;
      goff          = '0;
      ebytes        = '0;
      prior         = '0;
      stat          = STATUS_OK;

      case (entry.op)
         OP_ALLOC: begin
            ebytes = entry_bytes;
            if (filled_ff) begin
               stat = STATUS_FULL;
            end else if (next_ptr >= zone_size_ff || next_ptr < free_ptr_ff) begin
               filled_in = 1'b1;
               if (ready_cnt_ff == alloc_cnt_ff) begin
                  committed_in = 1'b1;
               end
               stat = STATUS_FULL;
            end else begin
               grant        = 1'b1;
               goff         = free_ptr_ff;
               free_ptr_in  = next_ptr;
               alloc_cnt_in = alloc_cnt_ff + 16'd1;
            end
         end
         OP_COMMIT: begin
            if (committed_ff || ready_cnt_ff >= alloc_cnt_ff ||
                entry.entry_offset < ZoneHeader || entry.entry_offset >= free_ptr_ff) begin
               stat = STATUS_REJECT;
            end else begin
               prior         = ready_head_ff;
               ready_head_in = entry.entry_offset;
               ready_cnt_in  = ready_plus;
               if (ready_plus == alloc_cnt_ff) begin
                  sync_point_in = free_ptr_ff;
                  if (filled_ff) begin
                     committed_in = 1'b1;
                  end
               end
            end
         end
         OP_MARK: begin
            if (filled_ff) begin
               stat = STATUS_REFUSED;
            end else begin
               filled_in = 1'b1;
               if (ready_cnt_ff == alloc_cnt_ff) begin
                  committed_in = 1'b1;
               end
            end
         end
         OP_RECYCLE: begin
            if (!filled_ff || !committed_ff) begin
               stat = STATUS_REFUSED;
            end else begin
               free_ptr_in   = ZoneHeader;
               sync_point_in = ZoneHeader;
               alloc_cnt_in  = '0;
               ready_cnt_in  = '0;
               ready_head_in = '0;
               filled_in     = 1'b0;
               committed_in  = 1'b0;
               generation_in = generation_ff + 32'd1;
               grant         = 1'b1;
            end
         end
         OP_QUERY: begin
            stat = STATUS_OK;
         end
         default: begin
            stat = STATUS_REFUSED;
         end
      endcase

      rsp_in.granted           = grant;
      rsp_in.granted_offset    = goff;
      rsp_in.entry_bytes       = ebytes;
      rsp_in.prior_head        = prior;
      rsp_in.status            = stat;
      rsp_in.zone_filled       = filled_in;
      rsp_in.zone_committed    = committed_in;
      rsp_in.entries_allocated = alloc_cnt_in;
      rsp_in.entries_ready     = ready_cnt_in;
      rsp_in.sync_offset       = sync_point_in;
      rsp_in.zone_generation   = generation_in;

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_size_ff  <= ZONE_SIZE_RESET;
         free_ptr_ff   <= ZoneHeader;
         alloc_cnt_ff  <= '0;
         ready_cnt_ff  <= '0;
         filled_ff     <= 1'b0;
         committed_ff  <= 1'b0;
         ready_head_ff <= '0;
         sync_point_ff <= '0;
         generation_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            zone_size_ff <= csr_zone_size;
         end
         if (pop) begin
            free_ptr_ff   <= free_ptr_in;
            alloc_cnt_ff  <= alloc_cnt_in;
            ready_cnt_ff  <= ready_cnt_in;
            filled_ff     <= filled_in;
            committed_ff  <= committed_in;
            ready_head_ff <= ready_head_in;
            sync_point_ff <= sync_point_in;
            generation_ff <= generation_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   // a committed zone is always a filled one
   a_committed_filled: assert property (@(posedge clock) disable iff (reset)
      committed_ff |-> filled_ff)
      else $error("committed flag set on a zone that is not filled");

   // bump pointer never drops below the zone header
   a_ptr_floor: assert property (@(posedge clock) disable iff (reset)
      free_ptr_ff >= ZoneHeader)
      else $error("free pointer below zone header");

   // a new beat never overwrites a response that is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !pop)
      else $error("response overwritten while stalled");

   // a held response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled response changed");

endmodule

// File: design/trace_zone_bump_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_zone_bump_allocator
// Bump pointer allocator for one trace buffer zone: allocate, commit,
// mark full, recycle and query commands, one response beat per command.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    command, request_size, entry_offset
//   rsp      out        rsp_valid/rsp_ready    granted ... zone_generation
//   csr      in         csr_valid/csr_ready    zone_size
//
// One command per cycle sustained while rsp_ready is held high; a request is
// decoded and its size rounded ahead of the queue, then executed from the
// queue head into the response register, which holds it until rsp_ready.
// The queue holds two beats, so req_ready drops only when the response side
// has stalled long enough to fill it.
// Reset is synchronous; zone state returns to empty, zone_size to 4096.
// csr_ready is always high.
// ----------------------------------------------------------------------------
module trace_zone_bump_allocator import tzba_pkg::*; #(
   parameter int ZONE_HEADER_BYTES  = ZONE_HEADER_BYTES_DEF,
   parameter int ENTRY_HEADER_BYTES = ENTRY_HEADER_BYTES_DEF,
   parameter int ALIGN_BYTES        = ALIGN_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_request_size,
   input  logic [15:0] req_entry_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_granted,
   output logic [15:0] rsp_granted_offset,
   output logic [15:0] rsp_entry_bytes,
   output logic [15:0] rsp_prior_head,
   output logic [1:0]  rsp_status,
   output logic        rsp_zone_filled,
   output logic        rsp_zone_committed,
   output logic [15:0] rsp_entries_allocated,
   output logic [15:0] rsp_entries_ready,
   output logic [15:0] rsp_sync_offset,
   output logic [31:0] rsp_zone_generation,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_zone_size
);

   queue_entry_type front_entry;
   queue_entry_type head_entry;
   logic            queue_full;
   logic            queue_not_empty;
   logic            pop;
   response_type    rsp;

   assign req_ready = !queue_full;

   tzba_front #(
      .ENTRY_HEADER_BYTES (ENTRY_HEADER_BYTES),
      .ALIGN_BYTES        (ALIGN_BYTES)
   ) u_front (
      .command      (req_command),
      .request_size (req_request_size),
      .entry_offset (req_entry_offset),
      .entry        (front_entry)
   );

   tzba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && req_ready),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .head_entry (head_entry)
   );

   tzba_back #(
      .ZONE_HEADER_BYTES (ZONE_HEADER_BYTES),
      .ALIGN_BYTES       (ALIGN_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .entry_valid   (queue_not_empty),
      .entry         (head_entry),
      .pop           (pop),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_zone_size (csr_zone_size),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp           (rsp)
   );

   assign rsp_granted           = rsp.granted;
   assign rsp_granted_offset    = rsp.granted_offset;
   assign rsp_entry_bytes       = rsp.entry_bytes;
   assign rsp_prior_head        = rsp.prior_head;
   assign rsp_status            = rsp.status;
   assign rsp_zone_filled       = rsp.zone_filled;
   assign rsp_zone_committed    = rsp.zone_committed;
   assign rsp_entries_allocated = rsp.entries_allocated;
   assign rsp_entries_ready     = rsp.entries_ready;
   assign rsp_sync_offset       = rsp.sync_offset;
   assign rsp_zone_generation   = rsp.zone_generation;

endmodule
